[hw/rtl/pcpm_pkg.sv]
package pcpm_pkg;

	localparam int LABEL_BITS = 4;
	localparam int Q_BITS     = 16;
	// quotient bits of one class precision: integer bit plus fifteen fraction bits
	localparam int PREC_STEPS = 16;
	localparam int STEP_BITS  = 5;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_REPORT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_ACC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                  sample;
		logic                  clear;
		logic                  report;
		logic                  load;
		logic                  step;
		logic                  acc;
		logic                  emit;
		logic [LABEL_BITS-1:0] cls;
	} cmd_t;

endpackage

[hw/rtl/pcpm_ctrl.sv]
module pcpm_ctrl #(
	parameter int CLASS_COUNT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	output logic               busy,
	output pcpm_pkg::cmd_t     cmd
);

	localparam int IW = $clog2(CLASS_COUNT);

	pcpm_pkg::state_t                    state_q;
	pcpm_pkg::state_t                    state_d;
	logic [IW-1:0]                       cls_q;
	logic [pcpm_pkg::STEP_BITS-1:0]      step_q;
	logic                                div_last;
	logic                                cls_last;

	assign div_last = step_q == pcpm_pkg::STEP_BITS'(pcpm_pkg::PREC_STEPS - 1);
	assign cls_last = cls_q == IW'(CLASS_COUNT - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcpm_pkg::ST_IDLE: begin
				if (start && op == pcpm_pkg::OP_REPORT) state_d = pcpm_pkg::ST_LOAD;
			end
			pcpm_pkg::ST_LOAD:   state_d = pcpm_pkg::ST_DIV;
			pcpm_pkg::ST_DIV: begin
				if (div_last) state_d = pcpm_pkg::ST_ACC;
			end
			pcpm_pkg::ST_ACC: begin
				state_d = cls_last ? pcpm_pkg::ST_EMIT : pcpm_pkg::ST_LOAD;
			end
			pcpm_pkg::ST_EMIT:   state_d = pcpm_pkg::ST_IDLE;
			default:             state_d = pcpm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.cls  = pcpm_pkg::LABEL_BITS'(cls_q);
		busy     = state_q != pcpm_pkg::ST_IDLE;
		case (state_q)
			pcpm_pkg::ST_IDLE: begin
				if (start) begin
					case (op)
						pcpm_pkg::OP_SAMPLE: cmd.sample = 1'b1;
						pcpm_pkg::OP_REPORT: cmd.report = 1'b1;
						pcpm_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
						default:             cmd.sample = 1'b0;
					endcase
				end
			end
			pcpm_pkg::ST_LOAD:   cmd.load  = 1'b1;
			pcpm_pkg::ST_DIV:    cmd.step  = 1'b1;
			pcpm_pkg::ST_ACC:    cmd.acc   = 1'b1;
			pcpm_pkg::ST_EMIT:   cmd.emit  = 1'b1;
			default:             cmd.emit  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpm_pkg::ST_IDLE;
			cls_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pcpm_pkg::ST_IDLE) begin
				cls_q <= '0;
			end else if (state_q == pcpm_pkg::ST_ACC) begin
				cls_q <= cls_q + 1'b1;
			end
			// step count runs while staying in the dividing state
			if (state_d == state_q && state_q == pcpm_pkg::ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(cmd.sample || cmd.clear || cmd.report))
		else $error("transfer command issued while busy");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.acc, cmd.emit}))
		else $error("more than one datapath phase at once");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcpm_pkg::ST_DIV |->
			step_q < pcpm_pkg::STEP_BITS'(pcpm_pkg::PREC_STEPS))
		else $error("class divide overran its steps");

	a_last_class: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcpm_pkg::ST_ACC && cls_last) |=> state_q == pcpm_pkg::ST_EMIT)
		else $error("emit not reached after last class");

	a_report_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |=> state_q == pcpm_pkg::ST_LOAD && cls_q == '0)
		else $error("report did not start at first class");
`endif

endmodule

[hw/rtl/pcpm_datapath.sv]
module pcpm_datapath #(
	parameter int CLASS_COUNT = 10,
	parameter int COUNT_BITS  = 16,
	parameter int SUM_BITS    = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pcpm_pkg::cmd_t                        cmd,
	input  logic [pcpm_pkg::LABEL_BITS-1:0]       true_label,
	input  logic [pcpm_pkg::LABEL_BITS-1:0]       predicted_label,
	input  logic [pcpm_pkg::LABEL_BITS-1:0]       query_class,
	output logic [pcpm_pkg::Q_BITS-1:0]           mean_precision,
	output logic [pcpm_pkg::Q_BITS-1:0]           class_precision,
	output logic                                  overflow,
	output logic                                  done
);

	localparam int IW  = $clog2(CLASS_COUNT);
	localparam int DW  = COUNT_BITS + 1;
	localparam int RW  = COUNT_BITS + 2;
	localparam int LW  = pcpm_pkg::LABEL_BITS + 1;
	localparam int QW  = pcpm_pkg::Q_BITS;
	// floor(sum / CLASS_COUNT) as sum * ceil(2^AVG_SHIFT / CLASS_COUNT) >> AVG_SHIFT,
	// exact for every sum below 2^SUM_BITS
	localparam int AVG_SHIFT = SUM_BITS + $clog2(CLASS_COUNT);
	localparam int RCW       = SUM_BITS + 1;
	localparam int PW        = SUM_BITS + RCW;
	localparam longint unsigned AVG_RECIP =
		((64'd1 << AVG_SHIFT) + 64'(CLASS_COUNT - 1)) / 64'(CLASS_COUNT);

	logic [COUNT_BITS-1:0] tp_q [CLASS_COUNT];
	logic [COUNT_BITS-1:0] fp_q [CLASS_COUNT];
	logic                  ovf_q;

	logic                  t_ok;
	logic                  p_ok;
	logic                  hit;
	logic [IW-1:0]         t_idx;
	logic [IW-1:0]         p_idx;
	logic [IW-1:0]         cls_idx;
	logic [IW-1:0]         tp_idx;
	logic [IW-1:0]         fp_idx;
	logic [COUNT_BITS-1:0] tp_rd;
	logic [COUNT_BITS-1:0] fp_rd;

	logic [DW-1:0]         den_q;
	logic [RW-1:0]         rem_q;
	logic [QW-1:0]         quo_q;
	logic                  zero_q;
	logic [DW-1:0]         den_load;
	logic                  ge;
	logic [RW-1:0]         rem_diff;
	logic [QW-1:0]         prec;

	logic [SUM_BITS-1:0]   sdiv_q;
	logic [PW-1:0]         avg_prod;

	logic                  qv_q;
	logic [IW-1:0]         qidx_q;
	logic [QW-1:0]         cp_q;
	logic [QW-1:0]         avg_out_q;
	logic [QW-1:0]         cp_out_q;
	logic                  ovf_out_q;
	logic                  done_q;

	assign t_ok    = {1'b0, true_label} < LW'(CLASS_COUNT);
	assign p_ok    = {1'b0, predicted_label} < LW'(CLASS_COUNT);
	assign t_idx   = true_label[IW-1:0];
	assign p_idx   = predicted_label[IW-1:0];
	assign cls_idx = cmd.cls[IW-1:0];
	assign hit     = true_label == predicted_label;

	// one read port per counter bank, shared by sample updates and the report sweep
	assign tp_idx = cmd.sample ? t_idx : cls_idx;
	assign fp_idx = cmd.sample ? p_idx : cls_idx;
	assign tp_rd  = tp_q[tp_idx];
	assign fp_rd  = fp_q[fp_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				tp_q[i] <= '0;
				fp_q[i] <= '0;
			end
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				tp_q[i] <= '0;
				fp_q[i] <= '0;
			end
			ovf_q <= 1'b0;
		end else if (cmd.sample && t_ok && p_ok) begin
			if (hit) begin
				if (&tp_rd) ovf_q <= 1'b1;
				else tp_q[tp_idx] <= tp_rd + 1'b1;
			end else begin
				if (&fp_rd) ovf_q <= 1'b1;
				else fp_q[fp_idx] <= fp_rd + 1'b1;
			end
		end
	end

	// restoring divide tp / (tp + fp), integer bit first then fifteen fraction bits
	assign den_load = DW'(tp_rd) + DW'(fp_rd);
	assign ge       = rem_q >= RW'(den_q);
	assign rem_diff = ge ? rem_q - RW'(den_q) : rem_q;
	assign prec     = zero_q ? '0 : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			den_q  <= den_load;
			rem_q  <= RW'(tp_rd);
			quo_q  <= '0;
			zero_q <= den_load == '0;
		end else if (cmd.step) begin
			rem_q <= {rem_diff[RW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			sdiv_q <= '0;
			cp_q   <= '0;
			qv_q   <= {1'b0, query_class} < LW'(CLASS_COUNT);
			qidx_q <= query_class[IW-1:0];
		end else if (cmd.acc) begin
			sdiv_q <= sdiv_q + SUM_BITS'(prec);
			if (qv_q && cls_idx == qidx_q) cp_q <= prec;
		end
	end

	assign avg_prod = PW'(sdiv_q) * PW'(AVG_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			avg_out_q <= avg_prod[AVG_SHIFT +: QW];
			cp_out_q  <= cp_q;
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign mean_precision    = avg_out_q;
	assign class_precision   = cp_out_q;
	assign overflow          = ovf_out_q;
	assign done              = done_q;

endmodule

[hw/rtl/per_class_precision_metric_top.sv]
// per-class and macro-average precision of a classifier, unsigned q1.15
// input channel: start with op, true_label, predicted_label and query_class;
// a transfer happens at a rising edge with start high and busy low
// op sample: counts a true positive (labels equal) or a false positive for the
// predicted class; busy stays low, so samples may arrive every cycle. labels
// at or above CLASS_COUNT drop the whole sample
// op clear: zeroes all counters and the overflow flag
// op report: busy rises for the sweep; each class runs a load step, a
// restoring divide and an accumulate step, then an emit step scales the
// sum by the reciprocal of CLASS_COUNT
// report end: done rises and busy falls at the edge that ends the emit step;
// the next transfer can be taken at the edge that ends the done cycle
// output: done is high for one cycle with mean_precision, class_precision
// and overflow; the receiver cannot stall and must take it then
// reset (arst_n low) clears all counters, the overflow flag and the controller
module per_class_precision_metric_top #(
	parameter int CLASS_COUNT = 10,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            op,
	input  logic [pcpm_pkg::LABEL_BITS-1:0]       true_label,
	input  logic [pcpm_pkg::LABEL_BITS-1:0]       predicted_label,
	input  logic [pcpm_pkg::LABEL_BITS-1:0]       query_class,
	output logic                                  done,
	output logic [pcpm_pkg::Q_BITS-1:0]           mean_precision,
	output logic [pcpm_pkg::Q_BITS-1:0]           class_precision,
	output logic                                  overflow
);

	localparam int SUM_BITS = pcpm_pkg::Q_BITS + $clog2(CLASS_COUNT);

	pcpm_pkg::cmd_t cmd;

	pcpm_ctrl #(
		.CLASS_COUNT (CLASS_COUNT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.cmd    (cmd)
	);

	pcpm_datapath #(
		.CLASS_COUNT (CLASS_COUNT),
		.COUNT_BITS  (COUNT_BITS),
		.SUM_BITS    (SUM_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.true_label        (true_label),
		.predicted_label   (predicted_label),
		.query_class       (query_class),
		.mean_precision    (mean_precision),
		.class_precision   (class_precision),
		.overflow          (overflow),
		.done              (done)
	);

endmodule

[tb/testbench.sv]
module testbench;

	localparam int CLASS_COUNT = 10;
	localparam int COUNT_BITS  = 16;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int REPORT_LATENCY = 18*CLASS_COUNT + 1;
	localparam int STALL_LIMIT = 2000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
	localparam longint unsigned Q_ONE = 32768;

	typedef struct packed {
		logic [pcpm_pkg::Q_BITS-1:0] average;
		logic [pcpm_pkg::Q_BITS-1:0] class_prec;
		logic                        ovf;
	} precision_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [1:0]                      op;
	logic [pcpm_pkg::LABEL_BITS-1:0] true_label;
	logic [pcpm_pkg::LABEL_BITS-1:0] predicted_label;
	logic [pcpm_pkg::LABEL_BITS-1:0] query_class;
	logic                            done;
	logic [pcpm_pkg::Q_BITS-1:0]     mean_precision;
	logic [pcpm_pkg::Q_BITS-1:0]     class_precision;
	logic                            overflow;

	// own copy of the counters
	logic [COUNT_BITS-1:0] tp_count[CLASS_COUNT];
	logic [COUNT_BITS-1:0] fp_count[CLASS_COUNT];
	logic                  overflow_flag;
	precision_t            pending_reports[$];

	bit pace_gaps;
	int errors;
	int mismatches;
	int stall_cycles;
	int n_samples;
	int n_dropped;
	int n_reports;
	int n_clears;
	int n_checked;

	per_class_precision_metric_top #(
		.CLASS_COUNT(CLASS_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.op               (op),
		.true_label       (true_label),
		.predicted_label  (predicted_label),
		.query_class      (query_class),
		.done             (done),
		.mean_precision   (mean_precision),
		.class_precision  (class_precision),
		.overflow         (overflow)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [COUNT_BITS-1:0] saturating_inc(logic [COUNT_BITS-1:0] v);
		if (v == COUNT_TOP) begin
			overflow_flag = 1'b1;
			return v;
		end
		return v + 1'b1;
	endfunction

	function automatic longint unsigned class_q15(int cls);
		longint unsigned tp;
		longint unsigned total;
		tp = tp_count[cls];
		total = tp + fp_count[cls];
		if (total == 0)
			return 0;
		return (tp * Q_ONE) / total;
	endfunction

	function automatic void clear_counts();
		for (int c = 0; c < CLASS_COUNT; c++) begin
			tp_count[c] = '0;
			fp_count[c] = '0;
		end
		overflow_flag = 1'b0;
	endfunction

	// applies one accepted transfer to the counter copy, queues a report if one is due
	function automatic void update_counts(logic [1:0] o, logic [3:0] t, logic [3:0] p,
			logic [3:0] q);
		longint unsigned sum;
		precision_t want;
		case (o)
			pcpm_pkg::OP_SAMPLE: begin
				if (t < CLASS_COUNT && p < CLASS_COUNT) begin
					if (t == p)
						tp_count[t] = saturating_inc(tp_count[t]);
					else
						fp_count[p] = saturating_inc(fp_count[p]);
					n_samples++;
				end else begin
					n_dropped++;
				end
			end
			pcpm_pkg::OP_CLEAR: begin
				clear_counts();
				n_clears++;
			end
			pcpm_pkg::OP_REPORT: begin
				sum = 0;
				for (int c = 0; c < CLASS_COUNT; c++)
					sum += class_q15(c);
				want.average = pcpm_pkg::Q_BITS'(sum / CLASS_COUNT);
				want.class_prec = (q < CLASS_COUNT) ? pcpm_pkg::Q_BITS'(class_q15(q)) : '0;
				want.ovf = overflow_flag;
				pending_reports.push_back(want);
				n_reports++;
			end
			default: begin
			end
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic send_item(logic [1:0] o, logic [3:0] t, logic [3:0] p, logic [3:0] q);
		int gap;
		gap = 0;
		@(negedge clk);
		while (pace_gaps && gap < 10 && $urandom_range(99) < 26) begin
			start <= 1'b0;
			gap++;
			@(negedge clk);
		end
		start           <= 1'b1;
		op              <= o;
		true_label      <= t;
		predicted_label <= p;
		query_class     <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		update_counts(o, t, p, q);
	endtask

	task automatic wait_for_reports();
		@(negedge clk);
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [3:0] pick_label();
		// mostly valid classes, sometimes anything the port allows
		if ($urandom_range(9) == 0)
			return 4'($urandom_range(15));
		return 4'($urandom_range(CLASS_COUNT-1));
	endfunction

	task automatic test_empty_report();
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd0);
		send_item(pcpm_pkg::OP_REPORT, 4'd15, 4'd15, 4'd9);
	endtask

	task automatic test_directed_cases();
		send_item(pcpm_pkg::OP_SAMPLE, 4'd0, 4'd0, 4'd15);
		send_item(pcpm_pkg::OP_SAMPLE, 4'd9, 4'd9, 4'd0);
		send_item(pcpm_pkg::OP_SAMPLE, 4'd0, 4'd9, 4'd0);
		// labels out of range drop the whole sample
		send_item(pcpm_pkg::OP_SAMPLE, 4'd15, 4'd15, 4'd0);
		send_item(pcpm_pkg::OP_SAMPLE, 4'd10, 4'd0, 4'd0);
		send_item(pcpm_pkg::OP_SAMPLE, 4'd0, 4'd12, 4'd0);
		send_item(OP_SPARE, 4'd15, 4'd15, 4'd15);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd0);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd9);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd15);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd10);
		send_item(pcpm_pkg::OP_SAMPLE, 4'd5, 4'd6, 4'd0);
		send_item(pcpm_pkg::OP_SAMPLE, 4'd6, 4'd5, 4'd0);
		send_item(pcpm_pkg::OP_SAMPLE, 4'd5, 4'd5, 4'd0);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd5);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd6);
		send_item(pcpm_pkg::OP_CLEAR, 4'd3, 4'd7, 4'd2);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd0);
	endtask

	// back-to-back samples with no gaps into class 3, then reports
	task automatic test_back_to_back();
		pace_gaps = 1'b0;
		send_item(pcpm_pkg::OP_CLEAR, 4'd0, 4'd0, 4'd0);
		for (int i = 0; i < 40; i++)
			send_item(pcpm_pkg::OP_SAMPLE, (i % 4 == 0) ? 4'd2 : 4'd3, 4'd3,
				4'($urandom_range(15)));
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd3);
		send_item(pcpm_pkg::OP_REPORT, 4'd0, 4'd0, 4'd2);
		pace_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		int pick;
		logic [3:0] t;
		logic [3:0] p;
		for (int i = 0; i < 690; i++) begin
			pace_gaps = !(i >= 280 && i < 400);
			if (i == 450)
				wait_for_reports();
			pick = $urandom_range(99);
			t = pick_label();
			p = ($urandom_range(1) == 0) ? t : pick_label();
			if (pick < 78)
				send_item(pcpm_pkg::OP_SAMPLE, t, p, 4'($urandom_range(15)));
			else if (pick < 92)
				send_item(pcpm_pkg::OP_REPORT, t, p, 4'($urandom_range(15)));
			else if (pick < 94)
				send_item(pcpm_pkg::OP_CLEAR, t, p, 4'($urandom_range(15)));
			else
				send_item(OP_SPARE, t, p, 4'($urandom_range(15)));
		end
		pace_gaps = 1'b1;
	endtask

	always @(posedge clk) begin : check_results
		precision_t got;
		precision_t want;
		if (arst_n) begin
			if (done) begin
				got = {mean_precision, class_precision, overflow};
				if (pending_reports.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("unexpected report: avg %0d class %0d ovf %0b",
							got.average, got.class_prec, got.ovf);
				end else begin
					want = pending_reports.pop_front();
					n_checked++;
					if (got !== want) begin
						errors++;
						mismatches++;
						if (mismatches <= SHOWN_MISMATCHES)
							$display({"report %0d: expected avg %0d class %0d ovf %0b, ",
								"got avg %0d class %0d ovf %0b"},
								n_checked, want.average, want.class_prec, want.ovf,
								got.average, got.class_prec, got.ovf);
					end
				end
			end
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles", STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		op              = pcpm_pkg::OP_SAMPLE;
		true_label      = '0;
		predicted_label = '0;
		query_class     = '0;
		pace_gaps       = 1'b1;
		errors          = 0;
		mismatches      = 0;
		stall_cycles    = 0;
		n_samples       = 0;
		n_dropped       = 0;
		n_reports       = 0;
		n_clears        = 0;
		n_checked       = 0;
		clear_counts();
		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_report();
		test_directed_cases();
		test_back_to_back();
		test_random_traffic();

		@(negedge clk);
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (REPORT_LATENCY + 20)
			@(posedge clk);
		if (pending_reports.size() != 0) begin
			errors++;
			$display("%0d reports never came out", pending_reports.size());
		end

		$display("covered %0d counted samples, %0d dropped labels, %0d clears,",
			n_samples, n_dropped, n_clears);
		$display("gap-free bursts and a full drain; checked %0d of %0d reports, %0d mismatches",
			n_checked, n_reports, mismatches);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/pcpm_pkg.sv
hw/rtl/pcpm_ctrl.sv
hw/rtl/pcpm_datapath.sv
hw/rtl/per_class_precision_metric_top.sv
tb/testbench.sv
